// ===== design/rsld_pkg.sv =====
// ----------------------------------------------------------------------------
// rsld_pkg
// shared types and constants of the run-length sprite line decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rsld_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned REG_W  = 11;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned COL_W  = 17;
  localparam int unsigned IDX_W  = 2;

  localparam logic [WORD_W-1:0] CODE_SKIP = 16'h00C0;
  localparam logic [WORD_W-1:0] CODE_COPY = 16'h00C1;

  localparam logic [IDX_W-1:0] REG_CLIP_LEFT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CLIP_RIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_LINE_COUNT = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] clip_left;
    logic [REG_W-1:0] clip_right;
    logic [REG_W-1:0] line_count;
  } cfg_t;

  typedef struct packed {
    logic              result_kind;
    logic [POS_W-1:0]  pixel_x;
    logic [POS_W-1:0]  pixel_y;
    logic [WORD_W-1:0] pixel_value;
  } result_t;

endpackage

`default_nettype wire

// ===== design/rsld_in_if.sv =====
// ----------------------------------------------------------------------------
// rsld_in_if
// stream word channel into the decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface rsld_in_if;
  logic                        valid;
  logic                        ready;
  logic [rsld_pkg::WORD_W-1:0] stream_word;
  logic                        image_start;

  modport source (output valid, output stream_word, output image_start, input ready);
  modport sink   (input valid, input stream_word, input image_start, output ready);
endinterface

`default_nettype wire

// ===== design/rsld_out_if.sv =====
// ----------------------------------------------------------------------------
// rsld_out_if
// result channel out of the decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface rsld_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [rsld_pkg::POS_W-1:0]  pixel_x;
  logic [rsld_pkg::POS_W-1:0]  pixel_y;
  logic [rsld_pkg::WORD_W-1:0] pixel_value;

  modport source (output valid, output result_kind, output pixel_x, output pixel_y,
                  output pixel_value, input ready);
  modport sink   (input valid, input result_kind, input pixel_x, input pixel_y,
                  input pixel_value, output ready);
endinterface

`default_nettype wire

// ===== design/rsld_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rsld_cfg_if
// register write channel of the decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface rsld_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rsld_pkg::IDX_W-1:0] index;
  logic [rsld_pkg::REG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/rsld_parser.sv =====
// ----------------------------------------------------------------------------
// rsld_parser
// line and run parser: updates the counters per stream word, forms a result
// ----------------------------------------------------------------------------
`default_nettype none

module rsld_parser (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        take,
  input  wire logic [rsld_pkg::WORD_W-1:0] word,
  input  wire logic                        image_start,
  input  wire rsld_pkg::cfg_t              cfg,
  output logic                             res_valid,
  output rsld_pkg::result_t                res
);

  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_CODE    = 3'd1,
    PH_SKIPCNT = 3'd2,
    PH_COPYCNT = 3'd3,
    PH_PIX     = 3'd4,
    PH_TRAIL   = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  localparam logic [rsld_pkg::COL_W-1:0] COL_MAX = '1;
  localparam logic [rsld_pkg::REG_W-1:0] WIDTH_LIM  = rsld_pkg::REG_W'(rsld_pkg::MAX_WIDTH);
  localparam logic [rsld_pkg::REG_W-1:0] HEIGHT_LIM = rsld_pkg::REG_W'(rsld_pkg::MAX_HEIGHT);

  phase_t                        phase_r, phase_nxt;
  logic [rsld_pkg::WORD_W-1:0]   line_left_r, line_left_nxt;
  logic [rsld_pkg::WORD_W-1:0]   run_left_r, run_left_nxt;
  logic [rsld_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [rsld_pkg::POS_W-1:0]    line_r, line_nxt;

  logic [rsld_pkg::REG_W-1:0]    lines_used;
  logic [rsld_pkg::REG_W-1:0]    right_lim;

  assign lines_used = (cfg.line_count > HEIGHT_LIM) ? HEIGHT_LIM : cfg.line_count;
  assign right_lim  = (cfg.clip_right > WIDTH_LIM) ? WIDTH_LIM : cfg.clip_right;

  always_comb begin
    logic [rsld_pkg::COL_W:0]   col_sum;
    logic [rsld_pkg::REG_W-1:0] line_inc;
    logic                       take_code;
    logic                       finish;

    phase_nxt     = phase_r;
    line_left_nxt = line_left_r;
    run_left_nxt  = run_left_r;
    col_nxt       = col_r;
    line_nxt      = line_r;
    res_valid     = 1'b0;
    res.result_kind = rsld_pkg::KIND_PIXEL;
    res.pixel_x     = col_r[rsld_pkg::POS_W-1:0];
    res.pixel_y     = line_r;
    res.pixel_value = word;
    take_code = 1'b0;
    finish    = 1'b0;

    if (image_start) begin
      line_nxt      = '0;
      col_nxt       = '0;
      run_left_nxt  = '0;
      line_left_nxt = '0;
      phase_nxt     = (lines_used == '0) ? PH_DONE : PH_LEN;
    end
    res.pixel_y = line_nxt;
    res.pixel_x = col_nxt[rsld_pkg::POS_W-1:0];
    col_sum = {1'b0, col_nxt} + {2'b0, word};

    unique case (phase_nxt)
      PH_LEN: begin
        col_nxt      = '0;
        run_left_nxt = '0;
        if (word == '0) begin
          finish = 1'b1;
        end else begin
          line_left_nxt = word - 1'b1;
          phase_nxt     = (line_left_nxt != '0) ? PH_CODE : PH_TRAIL;
        end
      end
      PH_CODE: begin
        if (word == rsld_pkg::CODE_SKIP) begin
          phase_nxt = PH_SKIPCNT;
        end else if (word == rsld_pkg::CODE_COPY) begin
          phase_nxt = PH_COPYCNT;
        end else begin
          res_valid       = 1'b1;
          res.result_kind = rsld_pkg::KIND_ERROR;
          res.pixel_x     = '0;
        end
        take_code = 1'b1;
      end
      PH_SKIPCNT: begin
        col_nxt   = col_sum[rsld_pkg::COL_W] ? COL_MAX : col_sum[rsld_pkg::COL_W-1:0];
        phase_nxt = PH_CODE;
        take_code = 1'b1;
      end
      PH_COPYCNT: begin
        run_left_nxt = word;
        phase_nxt    = (word != '0) ? PH_PIX : PH_CODE;
        take_code    = 1'b1;
      end
      PH_PIX: begin
        if (col_nxt >= {6'b0, cfg.clip_left} && col_nxt < {6'b0, right_lim}) begin
          res_valid = 1'b1;
        end
        if (col_nxt != COL_MAX) begin
          col_nxt = col_nxt + 1'b1;
        end
        if (run_left_nxt != '0) begin
          run_left_nxt = run_left_nxt - 1'b1;
        end
        phase_nxt = (run_left_nxt != '0) ? PH_PIX : PH_CODE;
        take_code = 1'b1;
      end
      PH_TRAIL: begin
        finish = 1'b1;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    if (take_code) begin
      if (line_left_nxt != '0) begin
        line_left_nxt = line_left_nxt - 1'b1;
      end
      if (line_left_nxt == '0) begin
        run_left_nxt = '0;
        phase_nxt    = PH_TRAIL;
      end
    end

    line_inc = {1'b0, line_nxt} + 1'b1;
    if (finish) begin
      col_nxt       = '0;
      run_left_nxt  = '0;
      line_left_nxt = '0;
      if (line_inc >= lines_used) begin
        phase_nxt = PH_DONE;
      end else begin
        line_nxt  = line_inc[rsld_pkg::POS_W-1:0];
        phase_nxt = PH_LEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN;
      line_left_r <= '0;
      run_left_r  <= '0;
      col_r       <= '0;
      line_r      <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      line_left_r <= line_left_nxt;
      run_left_r  <= run_left_nxt;
      col_r       <= col_nxt;
      line_r      <= line_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/rle_sprite_line_decoder_core.sv =====
// ----------------------------------------------------------------------------
// rle_sprite_line_decoder_core
// run-length sprite line decoder with clip window
// ----------------------------------------------------------------------------
// The decoder takes one stream word per clock cycle and gives at most one
// result per word in the next cycle, from a single output register: a
// clipped pixel with its column and line, or an error item for an unknown
// code word. The input stays ready while that register is empty or is
// being taken in the same cycle, so the rate is one item per cycle as long
// as the result side keeps up. Register writes are taken in every cycle and
// belong in idle periods only.
`default_nettype none

module rle_sprite_line_decoder_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rsld_in_if.sink     in_if,
  rsld_out_if.source  out_if,
  rsld_cfg_if.sink    cfg_if
);

  rsld_pkg::cfg_t    cfg_r;
  rsld_pkg::result_t res;
  rsld_pkg::result_t out_r;
  logic              res_valid;
  logic              out_valid_r;
  logic              in_take;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left  <= '0;
      cfg_r.clip_right <= rsld_pkg::REG_W'(rsld_pkg::MAX_WIDTH);
      cfg_r.line_count <= rsld_pkg::REG_W'(rsld_pkg::MAX_HEIGHT);
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        rsld_pkg::REG_CLIP_LEFT:  cfg_r.clip_left  <= cfg_if.data;
        rsld_pkg::REG_CLIP_RIGHT: cfg_r.clip_right <= cfg_if.data;
        rsld_pkg::REG_LINE_COUNT: cfg_r.line_count <= cfg_if.data;
        default: ;
      endcase
    end
  end

  rsld_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_take),
    .word        (in_if.stream_word),
    .image_start (in_if.image_start),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.result_kind = out_r.result_kind;
  assign out_if.pixel_x     = out_r.pixel_x;
  assign out_if.pixel_y     = out_r.pixel_y;
  assign out_if.pixel_value = out_r.pixel_value;

endmodule

`default_nettype wire
